FILE: hw/rtl/iprm_pkg.sv
// Shared constants, types and helpers for the ICMP probe reply matcher.
package iprm_pkg;

    localparam int MAX_PACKET     = 1024;
    localparam int CNT_W          = $clog2(MAX_PACKET + 1);
    localparam int HL_W           = 6;
    localparam int IP_HDR_BYTES   = 20;
    localparam int ICMP_HDR_BYTES = 28;
    localparam int ICMP_ID_OFS    = 4;
    localparam int ICMP_SEQ_OFS   = 6;
    localparam int ICMP_FIXED     = 8;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 8;

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_UNREACH       = 8'd3;
    localparam logic [7:0] TYPE_ECHO_REQ      = 8'd8;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    typedef enum logic [0:0] {
        REG_EXPECTED_ID  = 1'b0,
        REG_EXPECTED_SEQ = 1'b1
    } t_cfg_reg;

    // One packet byte handed to the tracker; valid means it is taken this cycle.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic reached;
        logic matches_res;
    } t_verdict;

    // IPv4 header length field in bytes.
    function automatic logic [HL_W-1:0] hdr_len(input logic [7:0] b);
        hdr_len = {b[3:0], 2'b00};
    endfunction

endpackage

FILE: hw/rtl/icmp_probe_reply_matcher.sv
// Top level of the ICMP probe reply matcher: stream ports, config registers, staging.
// Takes one IPv4 packet byte per cycle while input is not held off and, on the
// last byte, gives one item saying whether the packet answers the configured
// echo probe (echo reply with matching id and sequence, or a time exceeded or
// unreachable message quoting such an echo request). One byte is accepted
// every cycle unless input is held off. The last byte passes through the
// input register and the verdict is then kept in the result register, the two
// registers around the header tracker. The block only holds off input when a
// verdict is ready to be written while the previous one still waits at the
// output. Bytes beyond 1024 are ignored.
module icmp_probe_reply_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] pkt_byte
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] matches_res, [1] reached, [7:2] zero
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import iprm_pkg::*;

    t_item      r_in;
    t_item      trk_item;
    t_verdict   verdict;
    t_verdict   r_out;
    logic       r_out_valid;
    logic [15:0] r_expected_id, r_expected_seq;
    logic       advance;

    // A byte moves on unless it carries a verdict and the output is still full.
    assign advance       = r_in.valid && (!r_in.last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in.valid || advance;

    always_comb begin
        trk_item.valid = advance;
        trk_item.data  = r_in.data;
        trk_item.last  = r_in.last;
    end

    iprm_tracker u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (trk_item),
        .i_expected_id  (r_expected_id),
        .i_expected_seq (r_expected_seq),
        .o_verdict      (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in.valid <= s_axis_tvalid;
            r_in.data  <= s_axis_tdata;
            r_in.last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last) begin
            r_out <= verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id  <= '0;
            r_expected_seq <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_EXPECTED_ID:  r_expected_id  <= i_cfg_data;
                REG_EXPECTED_SEQ: r_expected_seq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - 2)'(0), r_out};

endmodule

FILE: hw/rtl/iprm_tracker.sv
// Per-packet header tracker and verdict logic for the ICMP probe reply matcher.
module iprm_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iprm_pkg::t_item    i_item,
    input  logic [15:0]        i_expected_id,
    input  logic [15:0]        i_expected_seq,
    output iprm_pkg::t_verdict o_verdict
);
    import iprm_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [HL_W-1:0]  r_outer_hl, n_outer_hl, r_inner_hl, n_inner_hl;
    logic [7:0]       r_outer_type, n_outer_type, r_inner_type, n_inner_type;
    logic             r_outer_id_ok, n_outer_id_ok, r_outer_seq_ok, n_outer_seq_ok;
    logic             r_inner_id_ok, n_inner_id_ok, r_inner_seq_ok, n_inner_seq_ok;

    logic             take;
    logic [7:0]       b;
    logic [HL_W-1:0]  h_eff, g_eff;
    logic [CNT_W-1:0] outer_base, inner_ip, inner_base;
    logic [CNT_W-1:0] len, n_outer_base, n_inner_hl_w, rem;
    logic             match;

    // Field updates for the current byte. The header lengths are taken from
    // the byte itself when it is the length byte, so a zero length lets the
    // same byte serve as the ICMP type.
    always_comb begin
        b          = i_item.data;
        take       = i_item.valid && (r_count < CNT_W'(MAX_PACKET));
        h_eff      = (r_count == '0) ? hdr_len(b) : r_outer_hl;
        outer_base = CNT_W'(h_eff);
        inner_ip   = outer_base + CNT_W'(ICMP_FIXED);
        g_eff      = (r_count == inner_ip) ? hdr_len(b) : r_inner_hl;
        inner_base = inner_ip + CNT_W'(g_eff);

        n_count        = r_count;
        n_outer_hl     = r_outer_hl;
        n_outer_type   = r_outer_type;
        n_outer_id_ok  = r_outer_id_ok;
        n_outer_seq_ok = r_outer_seq_ok;
        n_inner_hl     = r_inner_hl;
        n_inner_type   = r_inner_type;
        n_inner_id_ok  = r_inner_id_ok;
        n_inner_seq_ok = r_inner_seq_ok;

        if (take) begin
            n_count    = r_count + CNT_W'(1);
            n_outer_hl = h_eff;
            n_inner_hl = g_eff;
            if (r_count == outer_base) begin
                n_outer_type = b;
            end
            if (r_count == outer_base + CNT_W'(ICMP_ID_OFS)) begin
                n_outer_id_ok = (b == i_expected_id[15:8]);
            end
            if (r_count == outer_base + CNT_W'(ICMP_ID_OFS + 1)) begin
                n_outer_id_ok = r_outer_id_ok && (b == i_expected_id[7:0]);
            end
            if (r_count == outer_base + CNT_W'(ICMP_SEQ_OFS)) begin
                n_outer_seq_ok = (b == i_expected_seq[15:8]);
            end
            if (r_count == outer_base + CNT_W'(ICMP_SEQ_OFS + 1)) begin
                n_outer_seq_ok = r_outer_seq_ok && (b == i_expected_seq[7:0]);
            end
            if (r_count == inner_base) begin
                n_inner_type = b;
            end
            if (r_count == inner_base + CNT_W'(ICMP_ID_OFS)) begin
                n_inner_id_ok = (b == i_expected_id[15:8]);
            end
            if (r_count == inner_base + CNT_W'(ICMP_ID_OFS + 1)) begin
                n_inner_id_ok = r_inner_id_ok && (b == i_expected_id[7:0]);
            end
            if (r_count == inner_base + CNT_W'(ICMP_SEQ_OFS)) begin
                n_inner_seq_ok = (b == i_expected_seq[15:8]);
            end
            if (r_count == inner_base + CNT_W'(ICMP_SEQ_OFS + 1)) begin
                n_inner_seq_ok = r_inner_seq_ok && (b == i_expected_seq[7:0]);
            end
        end
    end

    // Verdict on the state as it stands once this byte has been taken.
    always_comb begin
        len          = n_count;
        n_outer_base = CNT_W'(n_outer_hl);
        n_inner_hl_w = CNT_W'(n_inner_hl);
        rem          = len - n_outer_base - CNT_W'(ICMP_FIXED);
        match        = 1'b0;
        if (len >= CNT_W'(IP_HDR_BYTES) &&
            len >= n_outer_base + CNT_W'(ICMP_HDR_BYTES)) begin
            if (n_outer_type == TYPE_ECHO_REPLY) begin
                match = n_outer_id_ok && n_outer_seq_ok;
            end else if (n_outer_type == TYPE_TIME_EXCEEDED ||
                         n_outer_type == TYPE_UNREACH) begin
                match = (rem >= CNT_W'(IP_HDR_BYTES)) &&
                        (rem >= n_inner_hl_w + CNT_W'(ICMP_HDR_BYTES)) &&
                        (n_inner_type == TYPE_ECHO_REQ) &&
                        n_inner_id_ok && n_inner_seq_ok;
            end
        end
        o_verdict.matches_res = match;
        o_verdict.reached     = match && (n_outer_type == TYPE_ECHO_REPLY);
    end

    // Everything is cleared after the final byte of a packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_item.valid && i_item.last)) begin
            r_count        <= '0;
            r_outer_hl     <= '0;
            r_outer_type   <= '0;
            r_outer_id_ok  <= 1'b0;
            r_outer_seq_ok <= 1'b0;
            r_inner_hl     <= '0;
            r_inner_type   <= '0;
            r_inner_id_ok  <= 1'b0;
            r_inner_seq_ok <= 1'b0;
        end else if (i_item.valid) begin
            r_count        <= n_count;
            r_outer_hl     <= n_outer_hl;
            r_outer_type   <= n_outer_type;
            r_outer_id_ok  <= n_outer_id_ok;
            r_outer_seq_ok <= n_outer_seq_ok;
            r_inner_hl     <= n_inner_hl;
            r_inner_type   <= n_inner_type;
            r_inner_id_ok  <= n_inner_id_ok;
            r_inner_seq_ok <= n_inner_seq_ok;
        end
    end

endmodule

FILE: hw/rtl/iprm_checker.sv
// Port-level checker for the ICMP probe reply matcher, bound to the top level.
module iprm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        i_cfg_we,
    input logic [0:0]  i_cfg_addr,
    input logic [15:0] i_cfg_data
);

    // A waiting result item is neither withdrawn nor altered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // Reaching the destination implies a match.
    a_reached_implies_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("reached set without a match");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
        else $error("result padding bits not zero");

    // A fresh result appears only after a final byte was accepted and passed through the input and result registers.
    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result item without a preceding final byte");

endmodule

bind icmp_probe_reply_matcher iprm_checker u_iprm_checker (.*);
